// ----- rtl/wnws_pkg.sv -----
// Package for the windowed nearest waypoint search block.
// Holds table sizes, field widths, register codes and the pipeline tag type.
// No dependencies.
`default_nettype none

package wnws_pkg;

	localparam int MAX_WAYPOINTS = 1024;
	localparam int COORD_BITS    = 24;
	localparam int IDX_BITS      = $clog2(MAX_WAYPOINTS);
	localparam int DIST_BITS     = 2 * COORD_BITS + 1;
	localparam int PATH_W        = 11;
	localparam int SEARCH_W      = 9;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 11;

	localparam logic [PATH_W-1:0]    PATH_MAX       = PATH_W'(MAX_WAYPOINTS);
	localparam logic [SEARCH_W-1:0]  SEARCH_RESET   = SEARCH_W'(50);

	localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH = CFG_IDX_W'(1);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Travels alongside a waypoint read through the distance pipeline
	typedef struct packed {
		logic                vld;
		logic [IDX_BITS-1:0] idx;
	} wnws_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} wnws_state_t;

endpackage

`default_nettype wire

// ----- rtl/wnws_store.sv -----
// Waypoint table: one write port, one read port with registered read data.
// Depends on wnws_pkg.
`default_nettype none

module wnws_store import wnws_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [IDX_BITS-1:0]          wr_addr,
	input  wire logic signed [COORD_BITS-1:0] wr_x,
	input  wire logic signed [COORD_BITS-1:0] wr_y,
	input  wire wnws_tag_t                    rd_tag,
	output wnws_tag_t                         rd_tag_s1,
	output logic signed [COORD_BITS-1:0]      rd_x_s1,
	output logic signed [COORD_BITS-1:0]      rd_y_s1
);

	logic [2*COORD_BITS-1:0] mem [MAX_WAYPOINTS];
	logic [2*COORD_BITS-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_y, wr_x};
		end
		if (rd_tag.vld) begin
			rd_data_s1 <= mem[rd_tag.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_s1 <= '0;
		end else begin
			rd_tag_s1 <= rd_tag;
		end
	end

	assign rd_x_s1 = rd_data_s1[COORD_BITS-1:0];
	assign rd_y_s1 = rd_data_s1[2*COORD_BITS-1:COORD_BITS];

endmodule

`default_nettype wire

// ----- rtl/wnws_dist.sv -----
// Shared squared-distance unit: magnitude, square, sum, one register each.
// Accepts one waypoint a cycle. Depends on wnws_pkg.
`default_nettype none

module wnws_dist import wnws_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic signed [COORD_BITS-1:0] qx,
	input  wire logic signed [COORD_BITS-1:0] qy,
	input  wire wnws_tag_t                    in_tag,
	input  wire logic signed [COORD_BITS-1:0] in_x,
	input  wire logic signed [COORD_BITS-1:0] in_y,
	output wnws_tag_t                         out_tag,
	output logic [DIST_BITS-1:0]              dist_sq,
	output logic                              busy
);

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      mag_x_s2, mag_y_s2;
	logic [2*COORD_BITS-1:0]    sq_x_s3, sq_y_s3;
	logic [DIST_BITS-1:0]       sum_s4;
	wnws_tag_t                  tag_s2, tag_s3, tag_s4;

	assign dx = {qx[COORD_BITS-1], qx} - {in_x[COORD_BITS-1], in_x};
	assign dy = {qy[COORD_BITS-1], qy} - {in_y[COORD_BITS-1], in_y};

	always_ff @(posedge clk) begin
		mag_x_s2 <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		mag_y_s2 <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		sq_x_s3  <= mag_x_s2 * mag_x_s2;
		sq_y_s3  <= mag_y_s2 * mag_y_s2;
		sum_s4   <= {1'b0, sq_x_s3} + {1'b0, sq_y_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= in_tag;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	assign out_tag = tag_s4;
	assign dist_sq = sum_s4;
	assign busy    = tag_s2.vld | tag_s3.vld | tag_s4.vld;

endmodule

`default_nettype wire

// ----- rtl/windowed_nearest_waypoint_search.sv -----
// Windowed nearest waypoint search: sequencer, registers and result stage.
// Depends on wnws_pkg, wnws_store and wnws_dist.
//
// Input channel s_*: s_tuser selects a load (0) or a query (1). A load writes
// one waypoint into the table in the cycle it is accepted and gives no result.
// A query scans the window from the progress pointer, cut off at path_length,
// and gives one result on m_*: nearest index, new progress pointer, and
// m_tuser set when the window held no waypoint.
// Configuration channel cfg_*: index 0 is path_length (saturates at the table
// size), index 1 is search_length; other indexes are dropped. Always ready.
// Query flow: a query with a window of N waypoints (N at most search_length)
// scans it from the pointer: the single distance unit takes one waypoint per
// cycle from the one table read port, then its magnitude, square and sum
// registers drain and the result is registered. An empty window skips the
// scan. s_tready is low meanwhile and rises together with m_tvalid when the
// result is registered, so no new item is taken while a query is running.
// A finished result sits in the output register; if the receiver stalls, a
// following load is still taken, a following query holds in its last step.
// Reset clears the pointer, path_length to 0 and search_length to 50. The
// table is not cleared: slots read by a query must have been loaded first.
`default_nettype none

module windowed_nearest_waypoint_search import wnws_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,  // waypoint_index, pos_x, pos_y, advance
	input  wire logic                  s_tuser,  // action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [23:0]                m_tdata,  // nearest_index, progress_index
	output logic                       m_tuser,  // window_empty
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	wnws_state_t state_q, state_d;

	logic [IDX_BITS-1:0]          in_idx;
	logic signed [COORD_BITS-1:0] in_x, in_y;
	logic                         in_adv;
	logic                         in_fire;

	logic [PATH_W-1:0]            path_len_q;
	logic [SEARCH_W-1:0]          search_len_q;
	logic [IDX_BITS-1:0]          ptr_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic                         adv_q;
	logic [IDX_BITS-1:0]          addr_q;
	logic [SEARCH_W-1:0]          remain_q;
	logic [DIST_BITS-1:0]         best_q;
	logic [IDX_BITS-1:0]          near_q;
	logic                         found_q;

	logic                         m_valid_q;
	logic [IDX_BITS-1:0]          m_near_q, m_prog_q;
	logic                         m_empty_q;

	logic [PATH_W-1:0]            win_end;
	logic [PATH_W-1:0]            win_sum;
	logic [SEARCH_W-1:0]          win_len;
	logic [PATH_W-1:0]            near_p1;
	logic [IDX_BITS-1:0]          ptr_next;

	logic                         store_wr;
	logic                         start_query;
	logic                         issue;
	logic                         finish;
	wnws_tag_t                    rd_tag, tag_s1, dist_tag;
	logic signed [COORD_BITS-1:0] wx_s1, wy_s1;
	logic [DIST_BITS-1:0]         dist_sq;
	logic                         dist_busy;

	assign in_idx  = s_tdata[9:0];
	assign in_x    = s_tdata[33:10];
	assign in_y    = s_tdata[57:34];
	assign in_adv  = s_tdata[58];
	assign in_fire = s_tvalid & s_tready;

	// window end = min(pointer + search_length, path_length)
	assign win_sum = {1'b0, ptr_q} + PATH_W'(search_len_q);
	assign win_end = (win_sum > path_len_q) ? path_len_q : win_sum;
	assign win_len = (win_end > {1'b0, ptr_q}) ?
		SEARCH_W'(win_end - {1'b0, ptr_q}) : '0;

	assign near_p1  = {1'b0, near_q} + PATH_W'(1);
	assign ptr_next = (found_q && adv_q) ?
		((near_p1 >= path_len_q) ? near_q : near_p1[IDX_BITS-1:0]) : ptr_q;

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		store_wr    = 1'b0;
		start_query = 1'b0;
		issue       = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_fire) begin
					if (s_tuser == ACT_LOAD) begin
						store_wr = (32'(in_idx) < MAX_WAYPOINTS);
					end else begin
						start_query = 1'b1;
						state_d     = (win_len == '0) ? ST_FINISH : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (remain_q == SEARCH_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!tag_s1.vld && !dist_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_len_q   <= '0;
			search_len_q <= SEARCH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATH_LENGTH: begin
					path_len_q <= (cfg_data > PATH_MAX) ? PATH_MAX : cfg_data;
				end
				REG_SEARCH_LENGTH: search_len_q <= cfg_data[SEARCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (start_query) begin
				found_q <= 1'b0;
			end else if (dist_tag.vld) begin
				found_q <= 1'b1;
			end
			if (finish) begin
				ptr_q     <= ptr_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_query) begin
			qx_q     <= in_x;
			qy_q     <= in_y;
			adv_q    <= in_adv;
			addr_q   <= ptr_q;
			remain_q <= win_len;
			near_q   <= ptr_q;
		end else begin
			if (issue) begin
				addr_q   <= addr_q + IDX_BITS'(1);
				remain_q <= remain_q - SEARCH_W'(1);
			end
			// strict less keeps the first index on a tie
			if (dist_tag.vld && (!found_q || dist_sq < best_q)) begin
				best_q <= dist_sq;
				near_q <= dist_tag.idx;
			end
		end
		if (finish) begin
			m_near_q  <= near_q;
			m_prog_q  <= ptr_next;
			m_empty_q <= ~found_q;
		end
	end

	assign rd_tag.vld = issue;
	assign rd_tag.idx = addr_q;

	wnws_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (store_wr),
		.wr_addr   (in_idx),
		.wr_x      (in_x),
		.wr_y      (in_y),
		.rd_tag    (rd_tag),
		.rd_tag_s1 (tag_s1),
		.rd_x_s1   (wx_s1),
		.rd_y_s1   (wy_s1)
	);

	wnws_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.qx      (qx_q),
		.qy      (qy_q),
		.in_tag  (tag_s1),
		.in_x    (wx_s1),
		.in_y    (wy_s1),
		.out_tag (dist_tag),
		.dist_sq (dist_sq),
		.busy    (dist_busy)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, m_prog_q, m_near_q};
	assign m_tuser  = m_empty_q;

endmodule

`default_nettype wire

// ----- rtl/wnws_chk.sv -----
// Port-level checker for the windowed nearest waypoint search block.
// Bound to the top level below. Depends on wnws_pkg.
`default_nettype none

module wnws_chk import wnws_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  s_tuser,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [23:0]           m_tdata,
	input wire logic                  m_tuser
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A query transaction occupies the block for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input taken during a query");

	// An empty window reports the pointer as the nearest index
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:0] == m_tdata[19:10])
		else $error("empty window with moved index");

	// The pointer never lies past nearest + 1
	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			{1'b0, m_tdata[19:10]} <= {1'b0, m_tdata[9:0]} + 11'd1)
		else $error("progress pointer out of place");

endmodule

bind windowed_nearest_waypoint_search wnws_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for windowed_nearest_waypoint_search.
// Depends on wnws_pkg and the RTL top; predicts every query result, scores the
// m_* stream in order, drives stream traffic with random gaps and cfg writes.
module tb_top;
	import wnws_pkg::*;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int ITEM_GOAL    = 1800;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_GAP   = 8;
	localparam int END_GAP      = 40;
	localparam int ROUTE_X0     = -2_500_000;
	localparam int ROUTE_Y0     = -400_000;
	localparam int ROUTE_STEP   = 4096;

	localparam logic signed [COORD_BITS-1:0] COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic [IDX_BITS-1:0] nearest;
		logic [IDX_BITS-1:0] progress;
		logic                empty;
	} nearest_fix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;  // waypoint_index, pos_x, pos_y, advance
	logic                  s_tuser = 1'b0; // action
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;  // nearest_index, progress_index
	logic                  m_tuser;  // window_empty
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the block state
	logic signed [COORD_BITS-1:0] wp_x [MAX_WAYPOINTS];
	logic signed [COORD_BITS-1:0] wp_y [MAX_WAYPOINTS];
	bit                           wp_loaded [MAX_WAYPOINTS];
	int                           track_ptr = 0;
	int                           path_len = 0;
	int                           search_len = 50;

	nearest_fix_t pending_fixes [$];
	nearest_fix_t head_fix;
	int           mismatches = 0;
	int           cycle_count = 0;
	int           items_sent = 0;
	int           next_slot = 0;
	bit           no_gaps = 1'b0;
	bit           hold_on = 1'b0;
	event         hold_go;

	windowed_nearest_waypoint_search dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic int window_end();
		int e;
		e = track_ptr + search_len;
		if (e > path_len) e = path_len;
		if (e > MAX_WAYPOINTS) e = MAX_WAYPOINTS;
		return e;
	endfunction

	// Scan the window from the pointer; first index wins on equal distance
	function automatic nearest_fix_t locate_nearest(input logic signed [COORD_BITS-1:0] qx,
			input logic signed [COORD_BITS-1:0] qy, input logic adv);
		nearest_fix_t fix;
		longint       best, dsq, dx, dy;
		int           i;
		fix.nearest = IDX_BITS'(track_ptr);
		fix.empty = 1'b1;
		best = 0;
		for (i = track_ptr; i < window_end(); i++) begin
			dx = qx;
			dy = qy;
			dx = dx - wp_x[i];
			dy = dy - wp_y[i];
			dsq = dx * dx + dy * dy;
			if (fix.empty || dsq < best) begin
				best = dsq;
				fix.nearest = IDX_BITS'(i);
				fix.empty = 1'b0;
			end
		end
		if (!fix.empty && adv)
			track_ptr = (int'(fix.nearest) + 1 >= path_len) ? int'(fix.nearest)
				: int'(fix.nearest) + 1;
		fix.progress = IDX_BITS'(track_ptr);
		return fix;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] route_x(input int i);
		return COORD_BITS'(ROUTE_X0 + i * ROUTE_STEP);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] route_y(input int i);
		return COORD_BITS'(ROUTE_Y0 + i * 900 + ((i * 37) % 101 - 50) * 40);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] any_coord();
		case ($urandom_range(7))
			0: return COORD_TOP;
			1: return COORD_BOT;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// Offer one stream item and predict it at the transaction
	task automatic send_item(input logic act, input logic [IDX_BITS-1:0] slot,
			input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] py,
			input logic adv);
		nearest_fix_t fix;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 22) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = {5'b0, adv, py, px, slot};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (act == ACT_LOAD) begin
			wp_x[slot] = px;
			wp_y[slot] = py;
			wp_loaded[slot] = 1'b1;
		end else begin
			fix = locate_nearest(px, py, adv);
			pending_fixes = {pending_fixes, fix};
		end
	endtask

	task automatic store_waypoint(input int slot, input logic signed [COORD_BITS-1:0] px,
			input logic signed [COORD_BITS-1:0] py);
		send_item(ACT_LOAD, IDX_BITS'(slot), px, py, 1'($urandom_range(1)));
	endtask

	// Fill any unloaded slot of the coming window first, then query
	task automatic seek_nearest(input logic signed [COORD_BITS-1:0] px,
			input logic signed [COORD_BITS-1:0] py, input logic adv);
		int i;
		for (i = track_ptr; i < window_end(); i++)
			if (!wp_loaded[i]) store_waypoint(i, route_x(i), route_y(i));
		send_item(ACT_QUERY, IDX_BITS'($urandom_range(MAX_WAYPOINTS - 1)), px, py, adv);
	endtask

	task automatic settle_block(input int gap);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle_block(SETTLE_GAP);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PATH_LENGTH)
			path_len = (val > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(val);
		else if (idx == REG_SEARCH_LENGTH)
			search_len = int'(val[SEARCH_W-1:0]);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk)
		m_tready = !hold_on && (no_gaps || $urandom_range(99) >= 22);

	// Receiver hold-off, counted on its own so the sender keeps pushing
	always begin
		@(hold_go);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fixes.size() == 0) begin
				flag_mismatch("result with no query pending");
			end else begin
				head_fix = pending_fixes.pop_front();
				if (m_tdata[IDX_BITS-1:0] !== head_fix.nearest)
					flag_mismatch($sformatf("nearest_index got %0d want %0d",
						m_tdata[IDX_BITS-1:0], head_fix.nearest));
				if (m_tdata[2*IDX_BITS-1:IDX_BITS] !== head_fix.progress)
					flag_mismatch($sformatf("progress_index got %0d want %0d",
						m_tdata[2*IDX_BITS-1:IDX_BITS], head_fix.progress));
				if (m_tuser !== head_fix.empty)
					flag_mismatch($sformatf("window_empty got %b want %b",
						m_tuser, head_fix.empty));
			end
		end
	end

	task automatic test_reset_state();
		// No path yet: empty window, pointer stays put even with advance
		seek_nearest('0, '0, 1'b1);
	endtask

	task automatic test_extreme_coords();
		store_waypoint(0, COORD_TOP, COORD_TOP);
		store_waypoint(1, COORD_BOT, COORD_BOT);
		store_waypoint(2, COORD_BOT, COORD_TOP);
		store_waypoint(3, COORD_TOP, COORD_BOT);
		store_waypoint(MAX_WAYPOINTS - 1, COORD_BOT, COORD_TOP);
		write_reg(REG_PATH_LENGTH, CFG_DATA_W'(4));
		seek_nearest(COORD_BOT, COORD_BOT, 1'b0);
		seek_nearest(COORD_TOP, COORD_TOP, 1'b0);
		seek_nearest(COORD_TOP, COORD_BOT, 1'b0);
		seek_nearest(COORD_BOT, COORD_TOP, 1'b0);
	endtask

	task automatic test_tie_break();
		store_waypoint(0, COORD_BITS'(100), '0);
		store_waypoint(1, -COORD_BITS'(100), '0);
		store_waypoint(2, '0, COORD_BITS'(100));
		seek_nearest('0, '0, 1'b1);
		seek_nearest('0, '0, 1'b0);
	endtask

	task automatic test_empty_window();
		write_reg(REG_SEARCH_LENGTH, '0);
		seek_nearest('0, '0, 1'b1);
		write_reg(REG_SEARCH_LENGTH, CFG_DATA_W'(50));
		write_reg(REG_PATH_LENGTH, CFG_DATA_W'(1));
		seek_nearest('0, '0, 1'b1);
		write_reg(REG_PATH_LENGTH, CFG_DATA_W'(4));
	endtask

	task automatic test_path_end();
		seek_nearest(COORD_TOP, COORD_BOT, 1'b1);
		seek_nearest(COORD_TOP, COORD_BOT, 1'b1);
		seek_nearest('0, '0, 1'b1);
	endtask

	task automatic test_register_corners();
		int r;
		for (r = int'(REG_SEARCH_LENGTH) + 1; r < 2 ** CFG_IDX_W; r++)
			write_reg(CFG_IDX_W'(r), '1);
		seek_nearest('0, '0, 1'b0);
		write_reg(REG_SEARCH_LENGTH, '1);
		seek_nearest(COORD_BOT, COORD_BOT, 1'b1);
	endtask

	// Vehicle following the route: path grows phase by phase, queries track the
	// pointer, with stray loads and far-off queries mixed in
	task automatic test_route_tracking();
		int  phase, grow, k, n, r, sl, tgt;
		int  plen;
		bit  full_seen;
		phase = 0;
		full_seen = 1'b0;
		next_slot = 4;
		while (items_sent < ITEM_GOAL) begin
			if (next_slot < MAX_WAYPOINTS) begin
				grow = $urandom_range(30, 110);
				if (grow > MAX_WAYPOINTS - next_slot) grow = MAX_WAYPOINTS - next_slot;
				for (k = 0; k < grow; k++)
					store_waypoint(next_slot + k, route_x(next_slot + k),
						route_y(next_slot + k));
				next_slot += grow;
			end
			r = $urandom_range(99);
			if (next_slot == MAX_WAYPOINTS && !full_seen) begin
				plen = 2 ** CFG_DATA_W - 1;
				full_seen = 1'b1;
			end else if (r < 15) begin
				plen = $urandom_range(next_slot);
			end else if (next_slot == MAX_WAYPOINTS) begin
				case ($urandom_range(2))
					0: plen = MAX_WAYPOINTS;
					1: plen = MAX_WAYPOINTS + 1;
					default: plen = 2 ** CFG_DATA_W - 1;
				endcase
			end else begin
				plen = next_slot;
			end
			write_reg(REG_PATH_LENGTH, CFG_DATA_W'(plen));
			r = $urandom_range(99);
			if (r < 8) sl = 0;
			else if (r < 15) sl = 256;
			else if (r < 18) sl = 2 ** SEARCH_W - 1;
			else sl = $urandom_range(1, 48);
			write_reg(REG_SEARCH_LENGTH, {2'($urandom_range(3)), SEARCH_W'(sl)});
			no_gaps = (phase == 3);
			n = $urandom_range(25, 60);
			for (k = 0; k < n; k++) begin
				r = $urandom_range(99);
				if (r < 85) begin
					tgt = track_ptr + $urandom_range(2);
					if (tgt > next_slot - 1) tgt = next_slot - 1;
					seek_nearest(COORD_BITS'(int'(route_x(tgt)) + int'($urandom_range(4000)) - 2000),
						COORD_BITS'(int'(route_y(tgt)) + int'($urandom_range(4000)) - 2000),
						1'($urandom_range(99) < 45));
				end else if (r < 93) begin
					store_waypoint($urandom_range(MAX_WAYPOINTS - 1), any_coord(), any_coord());
				end else begin
					seek_nearest(any_coord(), any_coord(), 1'($urandom_range(1)));
				end
			end
			no_gaps = 1'b0;
			phase++;
		end
	endtask

	task automatic test_receiver_stall();
		int k;
		write_reg(REG_SEARCH_LENGTH, CFG_DATA_W'(16));
		-> hold_go;
		for (k = 0; k < 8; k++)
			seek_nearest(route_x(track_ptr), route_y(track_ptr), 1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_extreme_coords();
		test_tie_break();
		test_empty_window();
		test_path_end();
		test_register_corners();
		test_route_tracking();
		test_receiver_stall();
		settle_block(END_GAP);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
